// ----- design/vdt_pkg.sv -----
// ----------------------------------------------------------------------------
// vdt_pkg
// Shared types and constants of the vertex deduplication table.
// ----------------------------------------------------------------------------
package vdt_pkg;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 12;
    localparam int TOTAL_W  = 13;

    localparam int CAPACITY_DEF   = 4096;
    localparam int HASH_SLOTS_DEF = 8192;

    // Hash seed and multiplier of the word mixing step.
    localparam logic [WORD_W-1:0] HASH_SEED = 32'h811C9DC5;
    localparam logic [WORD_W-1:0] MIX_K     = 32'h9E3779B1;

    // Input item: one vertex, or a request to clear the table.
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] rgba_color;
    } t_vdt_in;

    // Result item.
    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               accepted;
        logic               newly_added;
        logic [TOTAL_W-1:0] vertex_total;
    } t_vdt_out;

endpackage

// ----- design/vdt_ram.sv -----
// ----------------------------------------------------------------------------
// vdt_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/vdt_hash.sv -----
// ----------------------------------------------------------------------------
// vdt_hash
// Iterative vertex hash: one shared 32x32 multiplier mixes one word per cycle,
// then the hash is reduced to a slot number, by a mask or by shift-subtract.
// ----------------------------------------------------------------------------
module vdt_hash
    import vdt_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  t_vdt_in                       i_item,
    output logic                          o_done,
    output logic [$clog2(HASH_SLOTS)-1:0] o_slot
);

    localparam int SW         = $clog2(HASH_SLOTS);
    localparam bit SLOTS_POW2 = ((1 << SW) == HASH_SLOTS);
    localparam int K_TOP      = WORD_W - SW;
    localparam logic [WORD_W-1:0] DIV_INIT = WORD_W'(64'(HASH_SLOTS) << K_TOP);
    localparam logic [4:0] MOD_LAST = 5'(K_TOP);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_FIN  = 2'd2;
    localparam logic [1:0] H_MOD  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_k, n_k;
    logic [WORD_W-1:0] r_p, n_p;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_div, n_div;
    logic [4:0]        r_cnt, n_cnt;

    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   mix_in;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0]   h_fin;
    logic [WORD_W-1:0]   rem_step;

    always_comb begin
        case (r_k)
            2'd0:    word = i_item.pos_x;
            2'd1:    word = i_item.pos_y;
            2'd2:    word = i_item.pos_z;
            default: word = i_item.rgba_color;
        endcase
    end

    assign h_fin    = r_p ^ (r_p >> 15);
    assign mix_in   = ((r_k == 2'd0) ? HASH_SEED : h_fin) ^ word;
    assign prod     = mix_in * MIX_K;
    assign rem_step = (r_rem >= r_div) ? (r_rem - r_div) : r_rem;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_p     = r_p;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        o_done  = 1'b0;
        o_slot  = h_fin[SW-1:0];
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_k     = 2'd0;
                    n_state = H_MUL;
                end
            end
            H_MUL: begin
                n_p = prod[WORD_W-1:0];
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = H_FIN;
                end
            end
            H_FIN: begin
                if (SLOTS_POW2) begin
                    o_done  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    n_rem   = h_fin;
                    n_div   = DIV_INIT;
                    n_cnt   = MOD_LAST;
                    n_state = H_MOD;
                end
            end
            H_MOD: begin
                // One conditional subtract of the shifted slot count a cycle.
                n_rem = rem_step;
                n_div = r_div >> 1;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    o_done  = 1'b1;
                    o_slot  = rem_step[SW-1:0];
                    n_state = H_IDLE;
                end
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_k     <= 2'd0;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
        r_p   <= n_p;
        r_rem <= n_rem;
        r_div <= n_div;
    end

endmodule

// ----- design/vertex_dedup_table.sv -----
// ----------------------------------------------------------------------------
// vertex_dedup_table
// Exact-match vertex deduplication over a linear-probing hash table.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries one item: a vertex (mode 0)
// or a clear request (mode 1). Output channel o_out_valid / i_out_ready
// returns exactly one result item per input item, in order.
// A vertex item passes the multiply steps of the shared hash unit and a
// finish step, then for each probed slot a slot read and, if the slot is
// taken, a vertex read and a compare; its result then goes to the output
// register. When HASH_SLOTS is not a power of two the hash unit also
// reduces the hash by shift-subtract. A clear item skips the hash and the
// probe and goes straight to the result.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the following result is held until it is taken.
// After reset the block clears the slot table, one slot a cycle, before
// it raises o_in_ready. Clear items do not sweep:
// each stored vertex records its slot, and a slot counts as occupied only
// when it points below the vertex count at a vertex that points back.
// ----------------------------------------------------------------------------
module vertex_dedup_table
    import vdt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_vdt_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_vdt_out o_out_item
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(HASH_SLOTS);
    localparam int VW = SW + 4 * WORD_W;

    localparam logic [2:0] S_INIT      = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_HASH      = 3'd2;
    localparam logic [2:0] S_SLOT_RD   = 3'd3;
    localparam logic [2:0] S_SLOT_CHK  = 3'd4;
    localparam logic [2:0] S_STORE_CHK = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_probe, n_probe;
    logic [CW-1:0] r_count, n_count;
    t_vdt_in       r_item, n_item;
    t_vdt_out      r_res, n_res;
    t_vdt_out      r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          in_acc;
    logic          out_free;
    logic          hash_start;
    logic          hash_done;
    logic [SW-1:0] hash_slot;

    logic          slot_we;
    logic [SW-1:0] slot_waddr;
    logic [CW-1:0] slot_wdata;
    logic [CW-1:0] slot_rdata;

    logic          vt_we;
    logic [VW-1:0] vt_wdata;
    logic [IW-1:0] vt_raddr;
    logic [VW-1:0] vt_rdata;

    logic          slot_empty;
    logic          back_ok;
    logic          data_eq;
    logic          table_full;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign hash_start  = in_acc && !i_in_item.mode;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    vdt_hash #(
        .HASH_SLOTS(HASH_SLOTS)
    ) u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(hash_start),
        .i_item (r_item),
        .o_done (hash_done),
        .o_slot (hash_slot)
    );

    // Slot table: 0 is empty, k points at vertex k-1.
    vdt_ram #(
        .WIDTH(CW),
        .DEPTH(HASH_SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_raddr(r_slot),
        .o_rdata(slot_rdata)
    );

    // Vertex store: back-pointer to the owning slot, then the four words.
    vdt_ram #(
        .WIDTH(VW),
        .DEPTH(CAPACITY)
    ) u_vertex_ram (
        .i_clk  (i_clk),
        .i_we   (vt_we),
        .i_waddr(r_count[IW-1:0]),
        .i_wdata(vt_wdata),
        .i_raddr(vt_raddr),
        .o_rdata(vt_rdata)
    );

    assign vt_raddr   = IW'(slot_rdata - CW'(1));
    assign vt_wdata   = {r_slot, r_item.pos_x, r_item.pos_y, r_item.pos_z, r_item.rgba_color};
    assign slot_empty = (slot_rdata == '0) || (slot_rdata > r_count);
    assign back_ok    = (vt_rdata[VW-1:4*WORD_W] == r_slot);
    assign data_eq    = (vt_rdata[4*WORD_W-1:0] ==
                         {r_item.pos_x, r_item.pos_y, r_item.pos_z, r_item.rgba_color});
    assign table_full = (r_count >= CW'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_slot      = r_slot;
        n_probe     = r_probe;
        n_count     = r_count;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        slot_we     = 1'b0;
        slot_waddr  = r_slot;
        slot_wdata  = r_count + CW'(1);
        vt_we       = 1'b0;

        if (out_free && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                slot_wdata = '0;
                n_clr      = r_clr + SW'(1);
                if (r_clr == SW'(HASH_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_item;
                    if (i_in_item.mode) begin
                        n_count = '0;
                        n_res   = '{vertex_index: '0, accepted: 1'b1,
                                    newly_added: 1'b0, vertex_total: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_slot  = hash_slot;
                    n_probe = '0;
                    n_state = S_SLOT_RD;
                end
            end
            S_SLOT_RD: begin
                n_state = S_SLOT_CHK;
            end
            S_SLOT_CHK, S_STORE_CHK: begin
                if ((r_state == S_SLOT_CHK) && !slot_empty) begin
                    // Slot is taken: fetch the vertex it points at.
                    n_state = S_STORE_CHK;
                end else if ((r_state == S_STORE_CHK) && back_ok && data_eq) begin
                    n_res   = '{vertex_index: INDEX_W'(vt_raddr), accepted: 1'b1,
                                newly_added: 1'b0, vertex_total: TOTAL_W'(r_count)};
                    n_state = S_DONE;
                end else if ((r_state == S_SLOT_CHK) || !back_ok) begin
                    // Free slot, possibly one left over from before a clear.
                    if (table_full) begin
                        n_res = '{vertex_index: '0, accepted: 1'b0,
                                  newly_added: 1'b0, vertex_total: TOTAL_W'(r_count)};
                    end else begin
                        slot_we = 1'b1;
                        vt_we   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_res   = '{vertex_index: INDEX_W'(r_count), accepted: 1'b1,
                                    newly_added: 1'b1,
                                    vertex_total: TOTAL_W'(r_count + CW'(1))};
                    end
                    n_state = S_DONE;
                end else if (r_probe == SW'(HASH_SLOTS - 1)) begin
                    n_res   = '{vertex_index: '0, accepted: 1'b0,
                                newly_added: 1'b0, vertex_total: TOTAL_W'(r_count)};
                    n_state = S_DONE;
                end else begin
                    n_slot  = (r_slot == SW'(HASH_SLOTS - 1)) ? '0 : r_slot + SW'(1);
                    n_probe = r_probe + SW'(1);
                    n_state = S_SLOT_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_probe     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_probe     <= n_probe;
        end
        r_slot <= n_slot;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("vertex count exceeds capacity");

    a_refusal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.accepted) |->
        (!o_out_item.newly_added && (o_out_item.vertex_index == '0)))
        else $error("refused result carries an index or a new flag");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vt_we |=> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("vertex append did not advance the count");

    a_hash_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == S_HASH))
        else $error("hash unit finished outside the hash wait");

endmodule
